/* src/kd_pivot_bucket_partition_unit_defines.svh */
// Assertion macros for the checker file of the bucket partition unit
`ifndef KD_PIVOT_BUCKET_PARTITION_UNIT_DEFINES_SVH
`define KD_PIVOT_BUCKET_PARTITION_UNIT_DEFINES_SVH

// antecedent now, consequent in the next cycle
`define KDPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// antecedent and consequent in the same cycle
`define KDPB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/kdpb_pkg.sv */
// Package: constants, word types, control structs and helpers of the bucket partition unit
`default_nettype none
package kdpb_pkg;

	localparam int TREE_DEPTH  = 4;
	localparam int MAX_DIMS    = 10;
	localparam int POINT_CAP   = 65536;
	localparam int COORD_WIDTH = 32;

	localparam int NODE_COUNT   = (1 << TREE_DEPTH) - 1;
	localparam int BUCKET_COUNT = 1 << TREE_DEPTH;
	localparam int CNT_W        = $clog2(POINT_CAP + 1);
	localparam int ACC_W        = $clog2(longint'(BUCKET_COUNT) * longint'(POINT_CAP) + 1);
	localparam int POS_W        = 16;
	localparam int POS_MAX      = 65535;
	localparam int BUCKET_W     = 4;
	localparam int DIM_W        = 4;
	localparam int LVL_W        = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;

	localparam logic CFG_START_DIM   = 1'b0;
	localparam logic CFG_DIMS_IN_USE = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE_PIVOT = 2'd0,
		OP_COUNT       = 2'd1,
		OP_PLACE       = 2'd2,
		OP_CLEAR       = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t                        opcode;
		logic [3:0]                     pivot_index;
		logic signed [COORD_WIDTH-1:0]  coord_0;
		logic signed [COORD_WIDTH-1:0]  coord_1;
		logic signed [COORD_WIDTH-1:0]  coord_2;
		logic signed [COORD_WIDTH-1:0]  coord_3;
		logic signed [COORD_WIDTH-1:0]  coord_4;
		logic signed [COORD_WIDTH-1:0]  coord_5;
		logic signed [COORD_WIDTH-1:0]  coord_6;
		logic signed [COORD_WIDTH-1:0]  coord_7;
		logic signed [COORD_WIDTH-1:0]  coord_8;
		logic signed [COORD_WIDTH-1:0]  coord_9;
	} req_t;

	typedef struct packed {
		logic [BUCKET_W-1:0] bucket;
		logic [POS_W-1:0]    position;
		logic                overflow;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic reduce;
		logic step;
		logic pivot_we;
	} walk_cmd_t;

	typedef struct packed {
		logic dim_ok;
		logic last_level;
	} walk_sts_t;

	typedef struct packed {
		logic sum_init;
		logic sum_step;
		logic update;
		logic clear;
		logic place;
	} bank_cmd_t;

	typedef struct packed {
		logic sum_done;
	} bank_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_WALK,
		ST_SUM,
		ST_UPDATE,
		ST_RESP
	} seq_state_t;

	// low bits of the bucket number, zero extended when the tree is shallow
	function automatic logic [BUCKET_W-1:0] bucket_field(input logic [TREE_DEPTH-1:0] b);
		logic [TREE_DEPTH+BUCKET_W-1:0] t;
		t = {{BUCKET_W{1'b0}}, b};
		return t[BUCKET_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* src/kdpb_walk.sv */
// Pivot table and tree walk: one signed compare shared by all tree levels
`default_nettype none
module kdpb_walk import kdpb_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire walk_cmd_t             cmd,
	input  wire req_t                  item,
	input  wire logic [DIM_W-1:0]      start_dim,
	input  wire logic [DIM_W-1:0]      dims,
	output walk_sts_t                  sts,
	output logic [TREE_DEPTH-1:0]      bucket
);

	logic signed [COORD_WIDTH-1:0] pivot_q [1:NODE_COUNT];
	logic signed [COORD_WIDTH-1:0] coords [MAX_DIMS];
	logic [DIM_W-1:0]              d_q;
	logic [DIM_W-1:0]              d_inc;
	logic [TREE_DEPTH:0]           k_q;
	logic [LVL_W-1:0]              lvl_q;
	logic [TREE_DEPTH+3:0]         pidx_wide;
	logic                          pidx_ok;
	logic                          go_left;

	always_comb begin
		coords[0] = item.coord_0;
		coords[1] = item.coord_1;
		coords[2] = item.coord_2;
		coords[3] = item.coord_3;
		coords[4] = item.coord_4;
		coords[5] = item.coord_5;
		coords[6] = item.coord_6;
		coords[7] = item.coord_7;
		coords[8] = item.coord_8;
		coords[9] = item.coord_9;
	end

	assign pidx_wide = (TREE_DEPTH + 4)'(item.pivot_index);
	assign pidx_ok   = (item.pivot_index != 4'd0) && (int'(item.pivot_index) <= NODE_COUNT);

	// k stays below the leaf row during the walk, so its low bits address the node
	assign go_left = coords[d_q] < pivot_q[k_q[TREE_DEPTH-1:0]];
	assign d_inc   = ((d_q + DIM_W'(1)) == dims) ? '0 : d_q + DIM_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.pivot_we && pidx_ok) begin
			pivot_q[pidx_wide[TREE_DEPTH-1:0]] <= item.coord_0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q   <= '0;
			k_q   <= '0;
			lvl_q <= '0;
		end else if (cmd.load) begin
			d_q   <= start_dim;
			k_q   <= (TREE_DEPTH + 1)'(1);
			lvl_q <= '0;
		end else if (cmd.reduce) begin
			d_q <= d_q - dims;
		end else if (cmd.step) begin
			k_q   <= {k_q[TREE_DEPTH-1:0], ~go_left};
			d_q   <= d_inc;
			lvl_q <= lvl_q + LVL_W'(1);
		end
	end

	assign sts.dim_ok     = d_q < dims;
	assign sts.last_level = lvl_q == LVL_W'(TREE_DEPTH - 1);
	assign bucket         = k_q[TREE_DEPTH-1:0];

endmodule
`default_nettype wire

/* src/kdpb_bank.sv */
// Bucket counters and placed cursors with a shared accumulate adder for the prefix sweep
`default_nettype none
module kdpb_bank import kdpb_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bank_cmd_t             cmd,
	input  wire logic [TREE_DEPTH-1:0] bucket,
	output bank_sts_t                  sts,
	output logic [POS_W-1:0]           position,
	output logic                       overflow
);

	logic [CNT_W-1:0]      counts_q [BUCKET_COUNT];
	logic [CNT_W-1:0]      cursors_q [BUCKET_COUNT];
	logic [TREE_DEPTH-1:0] j_q;
	logic [ACC_W-1:0]      acc_q;
	logic [POS_W-1:0]      pos_q;
	logic                  ovf_q;
	logic [TREE_DEPTH-1:0] rd_idx;
	logic [CNT_W-1:0]      cnt_rd;
	logic [CNT_W-1:0]      cur_rd;
	logic [ACC_W-1:0]      sum;
	logic                  cnt_full;
	logic                  cur_full;
	logic                  cnt_big;
	logic                  sum_big;

	assign rd_idx = cmd.update ? bucket : j_q;
	assign cnt_rd = counts_q[rd_idx];
	assign cur_rd = cursors_q[bucket];

	// one adder: prefix terms during the sweep, then prefix plus cursor
	assign sum = acc_q + ACC_W'(cmd.update ? cur_rd : cnt_rd);

	assign cnt_full = cnt_rd >= CNT_W'(POINT_CAP);
	assign cur_full = cur_rd >= CNT_W'(POINT_CAP);
	assign cnt_big  = 64'(cnt_rd) > 64'(POS_MAX);
	assign sum_big  = 64'(sum) > 64'(POS_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUCKET_COUNT; i++) begin
				counts_q[i]  <= '0;
				cursors_q[i] <= '0;
			end
			j_q   <= '0;
			acc_q <= '0;
		end else begin
			if (cmd.clear) begin
				for (int i = 0; i < BUCKET_COUNT; i++) begin
					counts_q[i]  <= '0;
					cursors_q[i] <= '0;
				end
			end
			if (cmd.sum_init) begin
				j_q   <= '0;
				acc_q <= '0;
			end
			if (cmd.sum_step) begin
				acc_q <= sum;
				j_q   <= j_q + TREE_DEPTH'(1);
			end
			if (cmd.update) begin
				if (cmd.place) begin
					if (!cur_full) cursors_q[bucket] <= cur_rd + CNT_W'(1);
				end else begin
					if (!cnt_full) counts_q[bucket] <= cnt_rd + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (cmd.place) begin
				pos_q <= sum_big ? POS_W'(POS_MAX) : POS_W'(sum);
				ovf_q <= cur_full | sum_big;
			end else begin
				pos_q <= cnt_big ? POS_W'(POS_MAX) : POS_W'(cnt_rd);
				ovf_q <= cnt_full;
			end
		end
	end

	assign sts.sum_done = j_q == bucket;
	assign position     = pos_q;
	assign overflow     = ovf_q;

endmodule
`default_nettype wire

/* src/kd_pivot_bucket_partition_unit.sv */
// Top level: sequencer, config registers and result register of the bucket partition unit
//
//  channel  dir  handshake               word
//  req      in   req_valid / req_stall   req_t: opcode, pivot_index, coord_0..coord_9
//  rsp      out  rsp_valid / rsp_stall   rsp_t: bucket, position, overflow
//  cfg      in   cfg_we (no wait)        cfg_index, cfg_wdata
//
// One word at a time. R = start_dim / dims_in_use (whole part, 0..15) single-step
// reductions of the root dimension. Write and clear run the R reductions, then
// respond; count also walks the tree, one level per cycle through the shared compare.
// Place adds a prefix sweep over the lower buckets through the shared adder.
// Async reset clears counters, cursors and control; pivots hold garbage until written.
// req_stall is high from accept until the result moves to the output register;
// a stalled rsp only holds the block in its last state.
`default_nettype none
module kd_pivot_bucket_partition_unit import kdpb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [DIM_W-1:0] cfg_wdata
);

	seq_state_t            state_q, state_d;
	req_t                  item_q;
	logic [DIM_W-1:0]      start_dim_q;
	logic [DIM_W-1:0]      dims_q;
	logic [DIM_W-1:0]      dims_eff;
	walk_cmd_t             walk_cmd;
	walk_sts_t             walk_sts;
	bank_cmd_t             bank_cmd;
	bank_sts_t             bank_sts;
	logic [TREE_DEPTH-1:0] bucket;
	logic [POS_W-1:0]      bank_pos;
	logic                  bank_ovf;
	logic                  accept;
	logic                  rsp_load;
	logic                  rsp_free;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	rsp_t                  rsp_d;

	assign accept   = req_valid && !req_stall;
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (dims_q == '0) begin
			dims_eff = DIM_W'(1);
		end else if (int'(dims_q) > MAX_DIMS) begin
			dims_eff = DIM_W'(MAX_DIMS);
		end else begin
			dims_eff = dims_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_dim_q <= '0;
			dims_q      <= DIM_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_DIM:   start_dim_q <= cfg_wdata;
				CFG_DIMS_IN_USE: dims_q      <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (walk_sts.dim_ok) begin
					case (item_q.opcode)
						OP_WRITE_PIVOT: state_d = ST_RESP;
						OP_CLEAR:       state_d = ST_RESP;
						OP_COUNT:       state_d = ST_WALK;
						OP_PLACE:       state_d = ST_WALK;
						default:        state_d = ST_RESP;
					endcase
				end
			end
			ST_WALK: begin
				if (walk_sts.last_level) begin
					state_d = (item_q.opcode == OP_PLACE) ? ST_SUM : ST_UPDATE;
				end
			end
			ST_SUM: begin
				if (bank_sts.sum_done) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_RESP;
			ST_RESP: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		walk_cmd       = '0;
		bank_cmd       = '0;
		bank_cmd.place = item_q.opcode == OP_PLACE;
		req_stall      = 1'b1;
		rsp_load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall     = 1'b0;
				walk_cmd.load = accept;
			end
			ST_REDUCE: begin
				if (!walk_sts.dim_ok) begin
					walk_cmd.reduce = 1'b1;
				end else begin
					walk_cmd.pivot_we = item_q.opcode == OP_WRITE_PIVOT;
					bank_cmd.clear    = item_q.opcode == OP_CLEAR;
				end
			end
			ST_WALK: begin
				walk_cmd.step     = 1'b1;
				bank_cmd.sum_init = walk_sts.last_level;
			end
			ST_SUM: begin
				bank_cmd.sum_step = !bank_sts.sum_done;
			end
			ST_UPDATE: begin
				bank_cmd.update = 1'b1;
			end
			ST_RESP: begin
				rsp_load = rsp_free;
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp_d = '0;
		if (item_q.opcode inside {OP_COUNT, OP_PLACE}) begin
			rsp_d.bucket   = bucket_field(bucket);
			rsp_d.position = bank_pos;
			rsp_d.overflow = bank_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	kdpb_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (walk_cmd),
		.item      (item_q),
		.start_dim (start_dim_q),
		.dims      (dims_eff),
		.sts       (walk_sts),
		.bucket    (bucket)
	);

	kdpb_bank u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (bank_cmd),
		.bucket   (bucket),
		.sts      (bank_sts),
		.position (bank_pos),
		.overflow (bank_ovf)
	);

endmodule
`default_nettype wire

/* src/kdpb_checker.sv */
// Port-level checker for the bucket partition unit, bound to the top level
`default_nettype none
`include "kd_pivot_bucket_partition_unit_defines.svh"
module kdpb_port_props import kdpb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// an accepted word always keeps the block busy in the next cycle
	`KDPB_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall, "block took a second word right after the first")

	// a result only appears while a word is being worked on
	`KDPB_ASSERT_SAME(a_rsp_from_work, clk, arst_n, $rose(rsp_valid), $past(req_stall), "result appeared without work in progress")

	`KDPB_ASSERT_NEXT(a_rsp_held, clk, arst_n, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")

	`KDPB_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && rsp_stall, $stable(rsp), "stalled result word changed")

endmodule

bind kd_pivot_bucket_partition_unit kdpb_port_props u_kdpb_port_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
